[hw/rtl/dcmf_pkg.sv]
// Shared constants, payload structs and helpers for the dark channel minimum filter.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package dcmf_pkg;

   // Window geometry
   localparam int WINDOW      = 11;
   localparam int HALF        = WINDOW / 2;
   localparam int SPAN        = 2 * HALF + 1;
   localparam int LINES       = 2 * HALF;

   // Image geometry
   localparam int MAX_WIDTH   = 2048;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = COL_BITS + 1;
   localparam int MAX_HEIGHT  = 4096;
   localparam int ROW_BITS    = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int OUT_COL_BITS = 11;
   localparam int PIX_BITS    = 8;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Minimum tree over one column of the window
   localparam int TREE_LEVELS = $clog2(SPAN);
   localparam int TREE_LEAVES = 2 ** TREE_LEVELS;

   // Configuration port
   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_WIDTH_BITS  = 12;
   localparam int CSR_HEIGHT_BITS = 13;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 4'd1;

   typedef logic [PIX_BITS-1:0] pixel_type;

   typedef struct packed {
      pixel_type blue;
      pixel_type green;
      pixel_type red;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]     out_row;
      logic [OUT_COL_BITS-1:0] out_col;
      pixel_type               dark_value;
      logic                    last_of_run;
   } rsp_type;

   // One line store word: the dark values of one column over the previous rows
   typedef logic [LINES-1:0][PIX_BITS-1:0] line_word_type;

   typedef struct packed {
      logic                rd_en;
      logic [COL_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [COL_BITS-1:0] wr_addr;
   } ls_ctrl_type;

   function automatic pixel_type min8(input pixel_type a, input pixel_type b);
      min8 = (a < b) ? a : b;
   endfunction

endpackage

[hw/rtl/dcmf_cell.sv]
// One cell of the horizontal minimum chain: holds the minimum of a suffix of columns.
// Depends on dcmf_pkg.
`timescale 1ns / 1ps

module dcmf_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  dcmf_pkg::pixel_type push_value,
   input  dcmf_pkg::pixel_type prev_min,
   output dcmf_pkg::pixel_type cell_min
);

   dcmf_pkg::pixel_type min_ff;
   dcmf_pkg::pixel_type min_in;

   // take the neighbour's suffix minimum extended by the new column
   assign min_in = dcmf_pkg::min8(prev_min, push_value);

   always_ff @(posedge clock) begin
      if (shift_en) begin
         min_ff <= min_in;
      end
   end

   assign cell_min = min_ff;

endmodule

[hw/rtl/dcmf_cell_chain.sv]
// Row of SPAN minimum cells; the last cell holds the minimum over the last SPAN columns.
// Depends on dcmf_pkg and dcmf_cell.
`timescale 1ns / 1ps

module dcmf_cell_chain (
   input  logic                clock,
   input  logic                shift_en,
   input  dcmf_pkg::pixel_type push_value,
   output dcmf_pkg::pixel_type window_min
);

   dcmf_pkg::pixel_type link [dcmf_pkg::SPAN+1];

   // first cell sees no older column
   assign link[0] = '1;

   for (genvar i = 0; i < dcmf_pkg::SPAN; i++) begin : g_cell
      dcmf_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .push_value (push_value),
         .prev_min   (link[i]),
         .cell_min   (link[i+1])
      );
   end

   assign window_min = link[dcmf_pkg::SPAN];

endmodule

[hw/rtl/dcmf_line_store.sv]
// Line store: one word per column holding the dark values of the previous rows.
// Registered read with write-to-read forwarding for back-to-back same-column access. Uses dcmf_pkg.
`timescale 1ns / 1ps

module dcmf_line_store (
   input  logic                    clock,
   input  logic                    reset,
   input  dcmf_pkg::ls_ctrl_type   ctrl,
   input  dcmf_pkg::line_word_type wr_word,
   output dcmf_pkg::line_word_type rd_word
);

   dcmf_pkg::line_word_type mem [dcmf_pkg::MAX_WIDTH];
   dcmf_pkg::line_word_type rd_ff;
   dcmf_pkg::line_word_type fwd_word_ff;
   logic                    fwd_ff;
   logic                    fwd_in;

   // write port
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_word;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_ff       <= mem[ctrl.rd_addr];
         fwd_word_ff <= wr_word;
      end
   end

   // flag a read that collides with the write of the same edge
   assign fwd_in = ctrl.rd_en ? (ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr)) : fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_word = fwd_ff ? fwd_word_ff : rd_ff;

endmodule

[hw/rtl/dark_channel_min_filter.sv]
// Dark channel minimum filter: top level with counters, pipeline and output register.
// Depends on dcmf_pkg, dcmf_line_store and dcmf_cell_chain.
`timescale 1ns / 1ps

// Pixels enter in raster order at one per clock unless stalled. Each pixel's dark
// value (minimum of blue, green, red) is merged with the previous 2*(WINDOW/2) rows of
// its column, read from a line store of one word per column, and the column minimum is
// pushed into a row of WINDOW cells whose last cell holds the window minimum. A pixel
// within half a window of an edge also gives its own dark value. Results leave through
// a single output register: a pixel that causes two results (a completed interior
// window and its own border result, interior first) holds the input until its second
// result goes, so the sustained rate is one pixel per cycle apart from such pixels and
// output stalls. A write to either register restarts the frame. The line store needs no
// clearing pass after reset: no result uses a line before it is written.

module dark_channel_min_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  dcmf_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output dcmf_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dcmf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dcmf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int RB = dcmf_pkg::ROW_BITS;
   localparam int CB = dcmf_pkg::COL_BITS;
   localparam int WB = dcmf_pkg::WIDTH_BITS;
   localparam int HB = dcmf_pkg::HEIGHT_BITS;
   localparam int LN = dcmf_pkg::LINES;
   localparam int OB = dcmf_pkg::OUT_COL_BITS;

   // configuration and position
   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [dcmf_pkg::CSR_WIDTH_BITS-1:0]  csr_width_raw;
   logic [dcmf_pkg::CSR_HEIGHT_BITS-1:0] csr_height_raw;
   logic          cfg_restart;
   logic          last_col, last_row;

   // handshake
   logic adv, accept;

   // entry stage
   dcmf_pkg::pixel_type dark0;
   logic                border0, interior0;

   // stage 1
   logic                s1_valid_ff, s1_valid_in;
   dcmf_pkg::pixel_type s1_dark_ff;
   logic [RB-1:0]       s1_row_ff;
   logic [CB-1:0]       s1_col_ff;
   logic                s1_border_ff, s1_interior_ff;

   dcmf_pkg::ls_ctrl_type   ls_ctrl;
   dcmf_pkg::line_word_type ls_rd_word, ls_wr_word;
   dcmf_pkg::pixel_type     tree [dcmf_pkg::TREE_LEVELS+1][dcmf_pkg::TREE_LEAVES];
   dcmf_pkg::pixel_type     vmin;
   dcmf_pkg::pixel_type     window_min;
   logic                    push_en;

   // stage 2
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_int_ff, s2_int_in;
   logic                s2_bdr_ff, s2_bdr_in;
   dcmf_pkg::pixel_type s2_dark_ff;
   logic [RB-1:0]       s2_row_ff;
   logic [CB-1:0]       s2_col_ff;
   logic                s2_done, emit_int, emit_bdr;

   // output register
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   dcmf_pkg::rsp_type rsp_ff, rsp_in;

   // configuration writes, always accepted
   assign csr_ready      = 1'b1;
   assign csr_width_raw  = csr_wdata[dcmf_pkg::CSR_WIDTH_BITS-1:0];
   assign csr_height_raw = csr_wdata[dcmf_pkg::CSR_HEIGHT_BITS-1:0];
   assign cfg_restart    = csr_valid && ((csr_index == dcmf_pkg::CSR_IMAGE_WIDTH) ||
                                         (csr_index == dcmf_pkg::CSR_IMAGE_HEIGHT));

   // saturate written geometry to the usable range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && (csr_index == dcmf_pkg::CSR_IMAGE_WIDTH)) begin
         if (csr_width_raw == '0) begin
            width_in = WB'(1);
         end else if (32'(csr_width_raw) > 32'(dcmf_pkg::MAX_WIDTH)) begin
            width_in = WB'(dcmf_pkg::MAX_WIDTH);
         end else begin
            width_in = WB'(csr_width_raw);
         end
      end
      if (csr_valid && (csr_index == dcmf_pkg::CSR_IMAGE_HEIGHT)) begin
         if (csr_height_raw == '0) begin
            height_in = HB'(1);
         end else if (32'(csr_height_raw) > 32'(dcmf_pkg::MAX_HEIGHT)) begin
            height_in = HB'(dcmf_pkg::MAX_HEIGHT);
         end else begin
            height_in = HB'(csr_height_raw);
         end
      end
   end

   // advance the raster position per accepted transaction
   assign last_col = (WB'(col_ff) == (width_ff - WB'(1)));
   assign last_row = (HB'(row_ff) == (height_ff - HB'(1)));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : RB'(row_ff + RB'(1));
         end else begin
            col_in = CB'(col_ff + CB'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(dcmf_pkg::RESET_WIDTH);
         height_ff <= HB'(dcmf_pkg::RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // whole pipeline moves together once stage 2 can take a new pixel
   assign adv       = !s2_valid_ff || s2_done;
   assign accept    = req_valid && adv;
   assign req_stall = !adv;

   // dark value and result classes of the arriving pixel
   assign dark0 = dcmf_pkg::min8(dcmf_pkg::min8(req_data.blue, req_data.green), req_data.red);
   assign border0 = (row_ff < RB'(dcmf_pkg::HALF)) ||
                    ((HB'(row_ff) + HB'(dcmf_pkg::HALF)) >= height_ff) ||
                    (col_ff < CB'(dcmf_pkg::HALF)) ||
                    ((WB'(col_ff) + WB'(dcmf_pkg::HALF)) >= width_ff);
   assign interior0 = (row_ff >= RB'(LN)) && (col_ff >= CB'(LN));

   // stage 1: hold the pixel while its column word is read
   assign s1_valid_in = adv ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dark_ff     <= dark0;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_border_ff   <= border0;
         s1_interior_ff <= interior0;
      end
   end

   // read the column on entry, write it back as stage 1 moves on
   assign push_en         = s1_valid_ff && adv;
   assign ls_ctrl.rd_en   = accept;
   assign ls_ctrl.rd_addr = col_ff;
   assign ls_ctrl.wr_en   = push_en;
   assign ls_ctrl.wr_addr = s1_col_ff;

   // shift the new dark value into the column word, dropping the oldest row
   always_comb begin
      ls_wr_word[0] = s1_dark_ff;
      for (int i = 1; i < LN; i++) begin
         ls_wr_word[i] = ls_rd_word[i-1];
      end
   end

   dcmf_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ls_ctrl),
      .wr_word (ls_wr_word),
      .rd_word (ls_rd_word)
   );

   // vertical minimum over the column: balanced tree of compares
   always_comb begin
      for (int i = 0; i < dcmf_pkg::TREE_LEAVES; i++) begin
         tree[0][i] = '1;
      end
      tree[0][0] = s1_dark_ff;
      for (int i = 0; i < LN; i++) begin
         tree[0][i+1] = ls_rd_word[i];
      end
      for (int l = 0; l < dcmf_pkg::TREE_LEVELS; l++) begin
         for (int i = 0; i < dcmf_pkg::TREE_LEAVES; i++) begin
            tree[l+1][i] = '1;
         end
         for (int i = 0; i < (dcmf_pkg::TREE_LEAVES >> (l + 1)); i++) begin
            tree[l+1][i] = dcmf_pkg::min8(tree[l][2*i], tree[l][2*i+1]);
         end
      end
      vmin = tree[dcmf_pkg::TREE_LEVELS][0];
   end

   // horizontal minimum: cells update as the pixel enters stage 2
   dcmf_cell_chain u_cell_chain (
      .clock      (clock),
      .shift_en   (push_en),
      .push_value (vmin),
      .window_min (window_min)
   );

   // stage 2: hand out the interior result, then the border result
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_int = s2_valid_ff && s2_int_ff && out_free;
   assign emit_bdr = s2_valid_ff && !s2_int_ff && s2_bdr_ff && out_free;
   assign s2_done  = s2_valid_ff && (s2_int_ff ? (out_free && !s2_bdr_ff)
                                               : (!s2_bdr_ff || out_free));

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_int_in   = s2_int_ff;
      s2_bdr_in   = s2_bdr_ff;
      if (adv) begin
         s2_valid_in = s1_valid_ff;
         s2_int_in   = s1_interior_ff;
         s2_bdr_in   = s1_border_ff;
      end else if (emit_int) begin
         s2_int_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_int_ff   <= 1'b0;
         s2_bdr_ff   <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s2_int_ff   <= s2_int_in;
         s2_bdr_ff   <= s2_bdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         s2_dark_ff <= s1_dark_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit_int || emit_bdr;
         if (emit_int) begin
            rsp_in.out_row     = RB'(s2_row_ff - RB'(dcmf_pkg::HALF));
            rsp_in.out_col     = OB'(CB'(s2_col_ff - CB'(dcmf_pkg::HALF)));
            rsp_in.dark_value  = window_min;
            rsp_in.last_of_run = !s2_bdr_ff;
         end else begin
            rsp_in.out_row     = s2_row_ff;
            rsp_in.out_col     = OB'(s2_col_ff);
            rsp_in.dark_value  = s2_dark_ff;
            rsp_in.last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sim/tb_dark_channel_min_filter.sv]
// Self-checking testbench for dark_channel_min_filter: directed table then random frames.
// Depends on dcmf_pkg and the dark_channel_min_filter RTL; needs no other file.
`timescale 1ns / 1ps

module tb_dark_channel_min_filter;

   localparam int CLK_HALF_NS    = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int HOLD_CYCLES    = 200;
   localparam int RANDOM_PIXELS  = 1330;
   localparam longint TIMEOUT_NS = 3_000_000;

   localparam logic [dcmf_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 4'd7;

   typedef enum logic {ROW_PIXEL, ROW_CSR} stim_kind_type;

   typedef struct {
      stim_kind_type                       kind;
      logic [dcmf_pkg::CSR_INDEX_BITS-1:0] idx;
      logic [dcmf_pkg::CSR_DATA_BITS-1:0]  wdata;
      dcmf_pkg::req_type                   px;
      bit                                  typed;
      dcmf_pkg::rsp_type                   want;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   dcmf_pkg::req_type                   req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   dcmf_pkg::rsp_type                   rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [dcmf_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [dcmf_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Mirror of the filter: geometry, raster position and stored dark values
   logic [dcmf_pkg::CSR_WIDTH_BITS-1:0]  img_width  = 12'(dcmf_pkg::RESET_WIDTH);
   logic [dcmf_pkg::CSR_HEIGHT_BITS-1:0] img_height = 13'(dcmf_pkg::RESET_HEIGHT);
   int unsigned                          pos_row = 0;
   int unsigned                          pos_col = 0;
   dcmf_pkg::pixel_type                  past_dark [dcmf_pkg::LINES][dcmf_pkg::MAX_WIDTH];
   dcmf_pkg::pixel_type                  col_min [dcmf_pkg::SPAN];

   dcmf_pkg::rsp_type dark_expect_q[$];
   stim_row_type      directed_rows[$];
   dcmf_pkg::rsp_type rsp_want;

   int mismatch_count = 0;
   int pixels_sent    = 0;
   int results_seen   = 0;
   int pair_pixels    = 0;
   int silent_pixels  = 0;
   int csr_writes     = 0;
   int phase_count    = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int hold_left      = 0;
   bit hold_go        = 1'b0;

   dark_channel_min_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   // Hard limit on run time
   initial begin
      #(TIMEOUT_NS);
      $display("tb_dark_channel_min_filter: FAIL");
      $finish;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Append one expected result transaction
   function automatic void queue_result(input dcmf_pkg::rsp_type res);
      dark_expect_q.insert(dark_expect_q.size(), res);
   endfunction

   // Append one row of the directed table
   function automatic void add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic int unsigned eff_width();
      if (img_width == 0) return 1;
      if (img_width > dcmf_pkg::MAX_WIDTH) return dcmf_pkg::MAX_WIDTH;
      return 32'(img_width);
   endfunction

   function automatic int unsigned eff_height();
      if (img_height == 0) return 1;
      if (img_height > dcmf_pkg::MAX_HEIGHT) return dcmf_pkg::MAX_HEIGHT;
      return 32'(img_height);
   endfunction

   // Work out the results of one accepted pixel and queue them in order
   task automatic predict_dark(input dcmf_pkg::req_type px);
      int unsigned         w, h, r, c, k, n;
      dcmf_pkg::pixel_type dark, vmin, m;
      dcmf_pkg::rsp_type   res [2];
      w = eff_width();
      h = eff_height();
      r = pos_row;
      c = pos_col;
      n = 0;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;

      dark = (px.blue < px.green) ? px.blue : px.green;
      dark = (px.red < dark) ? px.red : dark;

      // Vertical minimum over this column, then store this row's dark value
      vmin = dark;
      for (k = 0; k < dcmf_pkg::LINES; k++)
         vmin = (past_dark[k][c] < vmin) ? past_dark[k][c] : vmin;
      past_dark[r % dcmf_pkg::LINES][c] = dark;
      col_min[c % dcmf_pkg::SPAN] = vmin;

      // Neighbourhood centred half a window up and left is now complete
      if (r >= dcmf_pkg::LINES && c >= dcmf_pkg::LINES) begin
         m = col_min[0];
         for (k = 1; k < dcmf_pkg::SPAN; k++)
            m = (col_min[k] < m) ? col_min[k] : m;
         res[n].out_row     = 12'(r - dcmf_pkg::HALF);
         res[n].out_col     = 11'(c - dcmf_pkg::HALF);
         res[n].dark_value  = m;
         res[n].last_of_run = 1'b0;
         n++;
      end

      // Pixel near an edge passes its own dark value
      if (r < dcmf_pkg::HALF || r + dcmf_pkg::HALF >= h ||
          c < dcmf_pkg::HALF || c + dcmf_pkg::HALF >= w) begin
         res[n].out_row     = 12'(r);
         res[n].out_col     = 11'(c);
         res[n].dark_value  = dark;
         res[n].last_of_run = 1'b0;
         n++;
      end

      if (n > 0) res[n-1].last_of_run = 1'b1;
      for (k = 0; k < n; k++)
         queue_result(res[k]);
      if (n == 2) pair_pixels++;
      if (n == 0) silent_pixels++;

      // Advance the raster position, wrapping at the end of the frame
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      pos_row = r;
      pos_col = c;
   endtask

   // Offer one pixel, idling first at the current rate, and predict once accepted
   task automatic send_pixel(input dcmf_pkg::req_type px, input bit typed,
                             input dcmf_pkg::rsp_type want);
      int depth;
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      depth = dark_expect_q.size();
      predict_dark(px);
      if (typed) begin
         if (dark_expect_q.size() != depth + 1 || dark_expect_q[$] != want)
            report_mismatch("directed row vs predictor", 64'(dark_expect_q[$]), 64'(want));
         while (dark_expect_q.size() > depth) void'(dark_expect_q.pop_back());
         queue_result(want);
      end
      @(negedge clock);
   endtask

   // Let the block go idle, then write one register
   task automatic write_csr(input logic [dcmf_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [dcmf_pkg::CSR_DATA_BITS-1:0] data);
      req_valid = 1'b0;
      while (dark_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
      if (idx == dcmf_pkg::CSR_IMAGE_WIDTH) begin
         img_width = data[dcmf_pkg::CSR_WIDTH_BITS-1:0];
         pos_row = 0;
         pos_col = 0;
      end else if (idx == dcmf_pkg::CSR_IMAGE_HEIGHT) begin
         img_height = data[dcmf_pkg::CSR_HEIGHT_BITS-1:0];
         pos_row = 0;
         pos_col = 0;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic dcmf_pkg::req_type rand_pixel();
      dcmf_pkg::req_type px;
      px.blue  = 8'($urandom_range(255));
      px.green = 8'($urandom_range(255));
      px.red   = 8'($urandom_range(255));
      // Pull one channel low now and then, or make the pixel white, so minima move around
      case ($urandom_range(9))
         0: px.blue  = 8'($urandom_range(15));
         1: px.green = 8'($urandom_range(15));
         2: px.red   = 8'($urandom_range(15));
         3: px = '1;
         default: ;
      endcase
      return px;
   endfunction

   function automatic stim_row_type pixel_row(input dcmf_pkg::pixel_type b,
                                              input dcmf_pkg::pixel_type g,
                                              input dcmf_pkg::pixel_type r);
      stim_row_type row;
      row.kind  = ROW_PIXEL;
      row.idx   = '0;
      row.wdata = '0;
      row.px    = {b, g, r};
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input dcmf_pkg::pixel_type b,
                                                input dcmf_pkg::pixel_type g,
                                                input dcmf_pkg::pixel_type r,
                                                input int out_r, input int out_c,
                                                input dcmf_pkg::pixel_type dark);
      stim_row_type row;
      row = pixel_row(b, g, r);
      row.typed = 1'b1;
      row.want.out_row     = 12'(out_r);
      row.want.out_col     = 11'(out_c);
      row.want.dark_value  = dark;
      row.want.last_of_run = 1'b1;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [dcmf_pkg::CSR_INDEX_BITS-1:0] idx,
                                            input logic [dcmf_pkg::CSR_DATA_BITS-1:0] data);
      stim_row_type row;
      row = pixel_row(8'h00, 8'h00, 8'h00);
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.wdata = data;
      return row;
   endfunction

   // Receiver: long hold-off on request, otherwise random stalls at the current rate
   always @(negedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dark_expect_q.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data), 64'(0));
         end else begin
            rsp_want = dark_expect_q.pop_front();
            results_seen++;
            if (rsp_data.out_row != rsp_want.out_row)
               report_mismatch("out_row", 64'(rsp_data.out_row), 64'(rsp_want.out_row));
            if (rsp_data.out_col != rsp_want.out_col)
               report_mismatch("out_col", 64'(rsp_data.out_col), 64'(rsp_want.out_col));
            if (rsp_data.dark_value != rsp_want.dark_value)
               report_mismatch("dark_value", 64'(rsp_data.dark_value),
                               64'(rsp_want.dark_value));
            if (rsp_data.last_of_run != rsp_want.last_of_run)
               report_mismatch("last_of_run", 64'(rsp_data.last_of_run),
                               64'(rsp_want.last_of_run));
         end
      end
   end

   initial begin
      int unsigned w_pick, h_pick, count, frame, pick;
      int          pixels_goal;

      // Directed rows: reset geometry, out-of-range sizes, ignored index, a tiny frame
      add_row(checked_row(8'hFF, 8'hFF, 8'hFF, 0, 0, 8'hFF));
      add_row(checked_row(8'h00, 8'hFF, 8'hFF, 0, 1, 8'h00));
      add_row(checked_row(8'hFF, 8'h00, 8'hFF, 0, 2, 8'h00));
      add_row(checked_row(8'hFF, 8'hFF, 8'h00, 0, 3, 8'h00));
      add_row(checked_row(8'hAA, 8'h55, 8'h80, 0, 4, 8'h55));
      add_row(csr_row(dcmf_pkg::CSR_IMAGE_WIDTH, 13'd0));
      add_row(csr_row(dcmf_pkg::CSR_IMAGE_HEIGHT, 13'd0));
      add_row(checked_row(8'h12, 8'h34, 8'h56, 0, 0, 8'h12));
      add_row(checked_row(8'hF0, 8'h0F, 8'hC3, 0, 0, 8'h0F));
      add_row(csr_row(dcmf_pkg::CSR_IMAGE_WIDTH, 13'd4095));
      add_row(csr_row(dcmf_pkg::CSR_IMAGE_HEIGHT, 13'd8191));
      add_row(checked_row(8'h80, 8'h7F, 8'h81, 0, 0, 8'h7F));
      add_row(csr_row(CSR_SPARE_INDEX, 13'h1FFF));
      add_row(checked_row(8'h01, 8'h02, 8'h03, 0, 1, 8'h01));
      add_row(csr_row(dcmf_pkg::CSR_IMAGE_WIDTH, 13'h1003));
      add_row(csr_row(dcmf_pkg::CSR_IMAGE_HEIGHT, 13'd2));
      add_row(checked_row(8'h10, 8'h20, 8'h30, 0, 0, 8'h10));
      add_row(checked_row(8'hFE, 8'h01, 8'h7F, 0, 1, 8'h01));
      add_row(checked_row(8'h40, 8'h40, 8'h3F, 0, 2, 8'h3F));
      add_row(checked_row(8'hC0, 8'hE0, 8'hD0, 1, 0, 8'hC0));
      add_row(checked_row(8'h00, 8'h00, 8'h00, 1, 1, 8'h00));
      add_row(checked_row(8'h99, 8'hAB, 8'hFF, 1, 2, 8'h99));
      add_row(pixel_row(8'h55, 8'hAA, 8'hFF));

      // Hold reset, then release at a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].idx, directed_rows[i].wdata);
         else
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases: new geometry, then a run of pixels under one idling pattern
      pixels_goal = RANDOM_PIXELS + directed_rows.size();
      while (pixels_sent < pixels_goal) begin
         case (phase_count % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 11; stall_pct = 11; end
         endcase

         pick = (phase_count == 0) ? 0 : $urandom_range(9);
         if (phase_count == 0) begin
            w_pick = 13;
            h_pick = 12;
         end else if (pick <= 5) begin
            w_pick = $urandom_range(11, 20);
            h_pick = $urandom_range(11, 16);
         end else if (pick == 6) begin
            w_pick = $urandom_range(1, 10);
            h_pick = $urandom_range(1, 30);
         end else if (pick == 7) begin
            w_pick = $urandom_range(11, 40);
            h_pick = $urandom_range(1, 10);
         end else if (pick == 8) begin
            case ($urandom_range(2))
               0: w_pick = dcmf_pkg::MAX_WIDTH;
               1: w_pick = 4095;
               default: w_pick = 13'h1000 | $urandom_range(11, 40);
            endcase
            case ($urandom_range(2))
               0: h_pick = dcmf_pkg::MAX_HEIGHT;
               1: h_pick = 8191;
               default: h_pick = 0;
            endcase
         end else begin
            w_pick = $urandom_range(11, 24);
            h_pick = $urandom_range(11, 16);
         end

         // Rewrite both registers, or just one of them now and then
         if (pick == 9 && $urandom_range(1) == 0) begin
            write_csr(dcmf_pkg::CSR_IMAGE_HEIGHT, 13'(h_pick));
         end else if (pick == 9) begin
            write_csr(dcmf_pkg::CSR_IMAGE_WIDTH, 13'(w_pick));
         end else begin
            write_csr(dcmf_pkg::CSR_IMAGE_WIDTH, 13'(w_pick));
            write_csr(dcmf_pkg::CSR_IMAGE_HEIGHT, 13'(h_pick));
         end

         frame = eff_width() * eff_height();
         if (phase_count == 0) count = frame + 5;
         else if (pick == 8) count = $urandom_range(40, 90);
         else if (frame > 400) count = 400;
         else count = (frame * $urandom_range(2, 3)) / 2;
         if (count > pixels_goal - pixels_sent) count = pixels_goal - pixels_sent;

         // One long receiver hold-off so the block backs up into its input
         if (phase_count == 2) hold_go = 1'b1;

         for (int i = 0; i < count; i++) begin
            // Sender pause until every outstanding result has drained
            if (phase_count == 5 && i == count / 2) begin
               req_valid = 1'b0;
               while (dark_expect_q.size() != 0) @(negedge clock);
            end
            send_pixel(rand_pixel(), 1'b0, '0);
         end
         phase_count++;
      end

      // Drain and let the pipeline settle
      req_valid = 1'b0;
      while (dark_expect_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d pixels over %0d geometry phases with %0d register writes.",
               pixels_sent, phase_count, csr_writes);
      $display("Checked %0d results: %0d pixels gave two, %0d gave none; %0d mismatches.",
               results_seen, pair_pixels, silent_pixels, mismatch_count);
      if (mismatch_count == 0 && dark_expect_q.size() == 0)
         $display("tb_dark_channel_min_filter: PASS");
      else
         $display("tb_dark_channel_min_filter: FAIL");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dcmf_pkg.sv
hw/rtl/dcmf_cell.sv
hw/rtl/dcmf_cell_chain.sv
hw/rtl/dcmf_line_store.sv
hw/rtl/dark_channel_min_filter.sv
sim/tb_dark_channel_min_filter.sv
